/* rtl/laser_row_centroid_macros.svh */
// Assertion macros for the laser row centroid block.
// Included by the top level only; depends on nothing else.
`ifndef LASER_ROW_CENTROID_MACROS_SVH
`define LASER_ROW_CENTROID_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LRC_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LRC_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lrc_pkg.sv */
// Shared constants, codes and types of the laser row centroid block.
// Used by the interfaces and by every module; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lrc_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W   = 8;
  localparam int WSUM_W  = 33;
  localparam int ISUM_W  = 20;
  localparam int FIELD_W = 12;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int PROD_W = PIX_W + COL_W;

  // The clamped quotient is below MAX_WIDTH, so COL_W quotient bits suffice.
  localparam int QUO_W = COL_W;
  localparam int CNT_W = $clog2(QUO_W + 1);

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic {
    KIND_POINT   = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  // One finished row, handed from the accumulator to the divider.
  typedef struct packed {
    logic [WSUM_W-1:0] wsum;
    logic [ISUM_W-1:0] isum;
    logic [ROW_W-1:0]  row;
    logic              has_point;
    logic              eof;
    logic              found;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

/* rtl/lrc_ifs.sv */
// Valid/ready stream interfaces for pixel beats and result beats.
// Depends on lrc_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lrc_pix_if;
  logic                      valid;
  logic                      ready;
  logic [lrc_pkg::PIX_W-1:0] pixel;
  logic                      end_of_row;
  logic                      end_of_frame;

  modport source (output valid, pixel, end_of_row, end_of_frame, input ready);
  modport sink   (input valid, pixel, end_of_row, end_of_frame, output ready);
endinterface

interface lrc_res_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [lrc_pkg::FIELD_W-1:0] x_index;
  logic [lrc_pkg::FIELD_W-1:0] row_index;
  logic                        found_any;
  logic                        last;

  modport source (output valid, kind, x_index, row_index, found_any, last, input ready);
  modport sink   (input valid, kind, x_index, row_index, found_any, last, output ready);
endinterface

`default_nettype wire

/* rtl/lrc_front.sv */
// Front end: accepts pixel beats, accumulates the row sums and queues finished rows that have a point or end a frame.
// Depends on lrc_pkg and lrc_pix_if.
`timescale 1ns / 1ps
`default_nettype none

module lrc_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  lrc_pix_if.sink             pix_i,
  input  lrc_pkg::fifo_stat_t stat_i,
  output logic                push_o,
  output lrc_pkg::job_t       job_o
);

  logic [lrc_pkg::WSUM_W-1:0] wsum_q, wsum_d;
  logic [lrc_pkg::ISUM_W-1:0] isum_q, isum_d;
  logic [lrc_pkg::COL_W-1:0]  col_q;
  logic [lrc_pkg::ROW_W-1:0]  row_q;
  logic                       seen_q;

  logic                       accept;
  logic                       row_end;
  logic                       has_point;
  logic [lrc_pkg::PROD_W-1:0] prod;
  logic [lrc_pkg::WSUM_W:0]   wsum_sum;
  logic [lrc_pkg::ISUM_W:0]   isum_sum;

  assign pix_i.ready = !stat_i.full;
  assign accept      = pix_i.valid && pix_i.ready;
  assign row_end     = pix_i.end_of_row || pix_i.end_of_frame;

  assign prod     = lrc_pkg::PROD_W'(pix_i.pixel) * lrc_pkg::PROD_W'(col_q);
  assign wsum_sum = {1'b0, wsum_q} + (lrc_pkg::WSUM_W + 1)'(prod);
  assign isum_sum = {1'b0, isum_q} + (lrc_pkg::ISUM_W + 1)'(pix_i.pixel);

  // Both sums saturate at all ones.
  assign wsum_d = wsum_sum[lrc_pkg::WSUM_W] ? '1 : wsum_sum[lrc_pkg::WSUM_W-1:0];
  assign isum_d = isum_sum[lrc_pkg::ISUM_W] ? '1 : isum_sum[lrc_pkg::ISUM_W-1:0];

  assign has_point = (wsum_d != '0) && (isum_d != '0);

  assign push_o          = accept && row_end && (has_point || pix_i.end_of_frame);
  assign job_o.wsum      = wsum_d;
  assign job_o.isum      = isum_d;
  assign job_o.row       = row_q;
  assign job_o.has_point = has_point;
  assign job_o.eof       = pix_i.end_of_frame;
  assign job_o.found     = seen_q || has_point;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsum_q <= '0;
      isum_q <= '0;
      col_q  <= '0;
      row_q  <= '0;
      seen_q <= 1'b0;
    end else if (accept) begin
      if (row_end) begin
        wsum_q <= '0;
        isum_q <= '0;
        col_q  <= '0;
        if (pix_i.end_of_frame) begin
          row_q  <= '0;
          seen_q <= 1'b0;
        end else begin
          if (row_q < lrc_pkg::ROW_W'(lrc_pkg::MAX_HEIGHT - 1)) begin
            row_q <= row_q + 1'b1;
          end
          seen_q <= seen_q || has_point;
        end
      end else begin
        wsum_q <= wsum_d;
        isum_q <= isum_d;
        if (col_q < lrc_pkg::COL_W'(lrc_pkg::MAX_WIDTH - 1)) begin
          col_q <= col_q + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/lrc_fifo.sv */
// Short queue of finished rows between the accumulator and the divider.
// Depends on lrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrc_fifo (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  lrc_pkg::job_t       job_i,
  input  wire                 pop_i,
  output lrc_pkg::job_t       job_o,
  output lrc_pkg::fifo_stat_t stat_o
);

  lrc_pkg::job_t                 mem_q [lrc_pkg::FIFO_DEPTH];
  logic [lrc_pkg::FIFO_PTR_W-1:0] wr_q;
  logic [lrc_pkg::FIFO_PTR_W-1:0] rd_q;
  logic [lrc_pkg::FIFO_CNT_W-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == lrc_pkg::FIFO_CNT_W'(lrc_pkg::FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign job_o        = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == lrc_pkg::FIFO_PTR_W'(lrc_pkg::FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == lrc_pkg::FIFO_PTR_W'(lrc_pkg::FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/lrc_back.sv */
// Back end: divides the row sums one quotient bit per cycle and emits result beats.
// Depends on lrc_pkg and lrc_res_if.
`timescale 1ns / 1ps
`default_nettype none

module lrc_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  lrc_pkg::job_t       job_i,
  input  lrc_pkg::fifo_stat_t stat_i,
  output logic                pop_o,
  lrc_res_if.source           res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_POINT,
    ST_SUMMARY
  } state_e;

  localparam logic [lrc_pkg::QUO_W-1:0] XMAX = lrc_pkg::QUO_W'(lrc_pkg::MAX_WIDTH - 1);

  state_e                      state_q;
  logic [lrc_pkg::ISUM_W-1:0]  isum_q;
  logic [lrc_pkg::ISUM_W-1:0]  rem_q;
  logic [lrc_pkg::QUO_W-1:0]   dvd_q;
  logic [lrc_pkg::QUO_W-1:0]   quo_q;
  logic [lrc_pkg::CNT_W-1:0]   cnt_q;
  logic [lrc_pkg::ROW_W-1:0]   row_q;
  logic                        eof_q;
  logic                        found_q;
  logic                        ovf_q;

  logic                        valid_q;
  lrc_pkg::kind_e              kind_q;
  logic [lrc_pkg::FIELD_W-1:0] x_q;
  logic [lrc_pkg::FIELD_W-1:0] rowo_q;
  logic                        found_o_q;
  logic                        last_q;

  logic                        ovf;
  logic [lrc_pkg::ISUM_W:0]    trial;
  logic [lrc_pkg::ISUM_W:0]    diff;
  logic                        ge;
  logic                        out_free;
  logic                        load_out;
  logic [lrc_pkg::QUO_W-1:0]   x_pt;

  // Quotient too large for QUO_W bits: the centroid clamps.
  assign ovf   = (job_i.wsum >> lrc_pkg::QUO_W) >= lrc_pkg::WSUM_W'(job_i.isum);
  assign trial = {rem_q, dvd_q[lrc_pkg::QUO_W-1]};
  assign diff  = trial - {1'b0, isum_q};
  assign ge    = trial >= {1'b0, isum_q};

  assign out_free = !valid_q || res_o.ready;
  // A new beat enters the output register in this cycle.
  assign load_out = out_free && ((state_q == ST_POINT) || (state_q == ST_SUMMARY));
  assign x_pt     = (ovf_q || (quo_q > XMAX)) ? XMAX : quo_q;
  assign pop_o    = (state_q == ST_IDLE) && !stat_i.empty;

  assign res_o.valid     = valid_q;
  assign res_o.kind      = logic'(kind_q);
  assign res_o.x_index   = x_q;
  assign res_o.row_index = rowo_q;
  assign res_o.found_any = found_o_q;
  assign res_o.last      = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      isum_q    <= '0;
      rem_q     <= '0;
      dvd_q     <= '0;
      quo_q     <= '0;
      cnt_q     <= '0;
      row_q     <= '0;
      eof_q     <= 1'b0;
      found_q   <= 1'b0;
      ovf_q     <= 1'b0;
      valid_q   <= 1'b0;
      kind_q    <= lrc_pkg::KIND_POINT;
      x_q       <= '0;
      rowo_q    <= '0;
      found_o_q <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      if (valid_q && res_o.ready && !load_out) begin
        valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (!stat_i.empty) begin
            isum_q  <= job_i.isum;
            rem_q   <= lrc_pkg::ISUM_W'(job_i.wsum >> lrc_pkg::QUO_W);
            dvd_q   <= job_i.wsum[lrc_pkg::QUO_W-1:0];
            quo_q   <= '0;
            cnt_q   <= '0;
            row_q   <= job_i.row;
            eof_q   <= job_i.eof;
            found_q <= job_i.found;
            ovf_q   <= ovf;
            if (!job_i.has_point) begin
              state_q <= ST_SUMMARY;
            end else if (ovf) begin
              state_q <= ST_POINT;
            end else begin
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          rem_q <= ge ? diff[lrc_pkg::ISUM_W-1:0] : trial[lrc_pkg::ISUM_W-1:0];
          quo_q <= lrc_pkg::QUO_W'({quo_q, ge});
          dvd_q <= lrc_pkg::QUO_W'({dvd_q, 1'b0});
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == lrc_pkg::CNT_W'(lrc_pkg::QUO_W - 1)) begin
            state_q <= ST_POINT;
          end
        end
        ST_POINT: begin
          if (out_free) begin
            valid_q   <= 1'b1;
            kind_q    <= lrc_pkg::KIND_POINT;
            x_q       <= lrc_pkg::FIELD_W'(x_pt);
            rowo_q    <= lrc_pkg::FIELD_W'(row_q);
            found_o_q <= 1'b0;
            last_q    <= !eof_q;
            state_q   <= eof_q ? ST_SUMMARY : ST_IDLE;
          end
        end
        ST_SUMMARY: begin
          if (out_free) begin
            valid_q   <= 1'b1;
            kind_q    <= lrc_pkg::KIND_SUMMARY;
            x_q       <= '0;
            rowo_q    <= '0;
            found_o_q <= found_q;
            last_q    <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/laser_row_centroid.sv */
// Top level of the laser row centroid block: accumulator, row queue and divider.
// Depends on lrc_pkg, lrc_ifs, lrc_front, lrc_fifo, lrc_back and the macro header.
//
//   channel  | dir | payload                                        | handshake
//   ---------+-----+------------------------------------------------+-------------
//   pix_i    | in  | pixel[7:0], end_of_row, end_of_frame           | valid/ready
//   res_o    | out | kind, x_index[11:0], row_index[11:0],          | valid/ready
//            |     | found_any, last                                |
//
// Pixel beats are taken one per clock while the row queue has room.
// Each row that yields a point passes the divider through a load step, the division at one
// quotient bit per cycle and an output step; the two-entry row queue hides this for rows
// that take at least as long to stream in, shorter rows stall the input via ready. A row
// whose centroid clamps skips the division and goes from the load to the output step. A
// frame summary follows the point as its own beat, or follows the load when the last row
// has no point. Reset is asynchronous, active low, and leaves the block empty with all sums
// and counters at zero.
// A stalled result sink fills the output register, then the queue, then stalls pixels.
`timescale 1ns / 1ps
`default_nettype none
`include "laser_row_centroid_macros.svh"

module laser_row_centroid (
  input  wire       clk_i,
  input  wire       rst_ni,
  lrc_pix_if.sink   pix_i,
  lrc_res_if.source res_o
);

  // Finished rows move from the accumulator to the divider through the queue.
  lrc_pkg::job_t       job_in;
  lrc_pkg::job_t       job_out;
  lrc_pkg::fifo_stat_t fifo_stat;
  logic                job_push;
  logic                job_pop;
  logic                push_to_empty;
  logic                summary_out;

  // The front end sums pixel * column and pixel over a row, saturating, and on the
  // last beat of a row (or frame) decides whether the row has a point.
  lrc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_i),
    .stat_i (fifo_stat),
    .push_o (job_push),
    .job_o  (job_in)
  );

  lrc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .job_i  (job_in),
    .pop_i  (job_pop),
    .job_o  (job_out),
    .stat_o (fifo_stat)
  );

  // The back end runs a restoring division, clamps the column and drives the
  // result beats: the point first, if the row has one, then the frame summary when the row ends a frame.
  lrc_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .job_i  (job_out),
    .stat_i (fifo_stat),
    .pop_o  (job_pop),
    .res_o  (res_o)
  );

  assign push_to_empty = job_push && fifo_stat.empty;
  assign summary_out   = res_o.valid && (res_o.kind == lrc_pkg::KIND_SUMMARY);

  // Queue must never be written while full or read while empty.
  `LRC_ASSERT_IMP(a_push_room, clk_i, rst_ni, job_push, !fifo_stat.full, "push into full queue")
  `LRC_ASSERT_IMP(a_pop_data, clk_i, rst_ni, job_pop, !fifo_stat.empty, "pop from empty queue")
  // A row pushed into an empty queue is visible on the next cycle.
  `LRC_ASSERT_NXT(a_push_lands, clk_i, rst_ni, push_to_empty, !fifo_stat.empty, "pushed row lost")
  // A frame summary always carries last.
  `LRC_ASSERT_IMP(a_summary_last, clk_i, rst_ni, summary_out, res_o.last, "summary without last")

endmodule

`default_nettype wire
